>>> sv/mf3rgb_pkg.sv
// Shared constants and types for the 3x3 RGB median filter.
package mf3rgb_pkg;

  // Line store depth and derived widths
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int NRES      = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Reset and minimum frame dimensions
  localparam logic [WID_W-1:0] RESET_WIDTH  = WID_W'(640);
  localparam logic [ROW_W-1:0] RESET_HEIGHT = ROW_W'(480);
  localparam int               MIN_DIM      = 3;

  // One pixel: channel 2 red, channel 1 green, channel 0 blue
  typedef logic [2:0][7:0] pix_t;

endpackage

>>> sv/median_filter_3x3_rgb_core.sv
// Top level of the 3x3 RGB median filter: counters, line stores, window, sort network.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | red_in_i, green_in_i, blue_in_i
//  out     | source    | out_valid_o/out_stall_i | out_row_o, out_col_o, *_out_o, is_border_o,
//          |           |                        | last_of_run_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel request is taken per cycle while the output does not stall; a request that
// yields several results holds the input while the result register drains them (two
// results at a row end, up to four on the last row). A request's results pass the line
// store read, the window shift with column sort, the median merge and the result
// register before they reach the output. Reset is asynchronous and needs no clearing pass:
// the line stores hold no state that a valid result reads before it is written. A stall
// on the output with a result pending holds the whole pipeline and the input together.
module median_filter_3x3_rgb_core
  import mf3rgb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           red_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           blue_in_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ROW_W-1:0]     out_row_o,
  output logic [10:0]          out_col_o,
  output logic [7:0]           red_out_o,
  output logic [7:0]           green_out_o,
  output logic [7:0]           blue_out_o,
  output logic                 is_border_o,
  output logic                 last_of_run_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Compare helpers
  // ---------------------------------------------------------------------------
  // Sort three values, packed as {max, med, min}
  function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [7:0] x, y, z, t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    return {z, y, x};
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] lo, hi, hc;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hc = (hi < c) ? hi : c;
    return (lo > hc) ? lo : hc;
  endfunction

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic [WID_W-1:0] width_q;
  logic [ROW_W-1:0] height_q;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;

  logic             adv;
  logic             accept;

  // position of the current request
  logic             wrap_c;
  logic [ROW_W:0]   row_pre;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;
  logic [WID_W-1:0] c_nxt;
  logic             end_row;
  logic [ROW_W:0]   r_nxt;
  logic             w_last, h_last, interior;
  logic [NRES-1:0]  emit;
  pix_t             pix_in;

  // stage 1: line store read
  logic             s1_valid_q;
  pix_t             s1_pix_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic [NRES-1:0]  s1_emit_q;
  logic             s1_border_q;
  logic [47:0]      line_mem [MAX_WIDTH];
  logic [47:0]      rd_q;

  // stage 2: window
  pix_t             win_q [9];
  logic             s2_valid_q;
  logic [ROW_W-1:0] s2_row_q;
  logic [COL_W-1:0] s2_col_q;
  logic [NRES-1:0]  s2_emit_q;
  logic             s2_border_q;
  pix_t             srt_min [3];
  pix_t             srt_mid [3];
  pix_t             srt_max [3];

  // stage 3: sorted columns
  logic             s3_valid_q;
  logic [ROW_W-1:0] s3_row_q;
  logic [COL_W-1:0] s3_col_q;
  logic [NRES-1:0]  s3_emit_q;
  logic             s3_border_q;
  pix_t             s3_min_q [3];
  pix_t             s3_mid_q [3];
  pix_t             s3_max_q [3];
  pix_t             s3_ctr_q, s3_right_q, s3_below_q, s3_corner_q;
  pix_t             med_pix;

  // result register
  logic [NRES-1:0]  pend_q;
  logic [NRES-1:0]  pend_rest;
  logic [ROW_W-1:0] b_row_q;
  logic [COL_W-1:0] b_col_q;
  pix_t             b_pix0_q, b_pix1_q, b_pix2_q, b_pix3_q;
  logic             b_border_q;
  pix_t             out_pix;

  // ---------------------------------------------------------------------------
  // Configuration registers, stored already clamped
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          if (int'(cfg_data_i) < MIN_DIM)          width_q <= WID_W'(MIN_DIM);
          else if (int'(cfg_data_i) > MAX_WIDTH)   width_q <= WID_W'(MAX_WIDTH);
          else                                     width_q <= WID_W'(cfg_data_i);
        end
        CFG_IMAGE_HEIGHT: begin
          if (int'(cfg_data_i) < MIN_DIM) height_q <= ROW_W'(MIN_DIM);
          else                            height_q <= cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: advance the pipeline when the result register frees up
  // ---------------------------------------------------------------------------
  assign pend_rest  = pend_q & (pend_q - NRES'(1));
  assign adv        = (pend_q == '0) || (!out_stall_i && (pend_rest == '0));
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign pix_in     = {red_in_i, green_in_i, blue_in_i};

  // ---------------------------------------------------------------------------
  // Row and column of the current request, and of the next one
  // ---------------------------------------------------------------------------
  always_comb begin
    wrap_c   = WID_W'(col_q) >= width_q;
    row_pre  = {1'b0, row_q} + (ROW_W+1)'(wrap_c);
    r_cur    = (row_pre >= {1'b0, height_q}) ? '0 : row_pre[ROW_W-1:0];
    c_cur    = wrap_c ? '0 : col_q;
    c_nxt    = WID_W'(c_cur) + WID_W'(1);
    end_row  = c_nxt >= width_q;
    r_nxt    = {1'b0, r_cur} + (ROW_W+1)'(1);
    col_d    = end_row ? '0 : c_nxt[COL_W-1:0];
    row_d    = r_cur;
    if (end_row) begin
      row_d = (r_nxt >= {1'b0, height_q}) ? '0 : r_nxt[ROW_W-1:0];
    end
    // which results this request produces
    w_last   = WID_W'(c_cur) == (width_q - WID_W'(1));
    h_last   = r_cur == (height_q - ROW_W'(1));
    interior = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    emit[0]  = (r_cur != '0) && (c_cur != '0);
    emit[1]  = (r_cur != '0) && w_last;
    emit[2]  = h_last && (c_cur != '0);
    emit[3]  = h_last && w_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read both line stores at the current column
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q    <= pix_in;
      s1_row_q    <= r_cur;
      s1_col_q    <= c_cur;
      s1_emit_q   <= emit;
      s1_border_q <= !interior;
    end
  end

  // Line stores as one word: older row in the upper half, newer row in the lower half
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= line_mem[c_cur];
    end
    if (adv && s1_valid_q) begin
      line_mem[s1_col_q] <= {rd_q[23:0], s1_pix_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: shift the window, sort each window column
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i*3]   <= win_q[i*3+1];
          win_q[i*3+1] <= win_q[i*3+2];
        end
        win_q[2] <= rd_q[47:24];
        win_q[5] <= rd_q[23:0];
        win_q[8] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_row_q    <= s1_row_q;
      s2_col_q    <= s1_col_q;
      s2_emit_q   <= s1_emit_q;
      s2_border_q <= s1_border_q;
    end
  end

  // Sort the three pixels of each window column, channel by channel
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        {srt_max[j][k], srt_mid[j][k], srt_min[j][k]} =
          sort3(win_q[j][k], win_q[3+j][k], win_q[6+j][k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: merge the sorted columns into the median
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_row_q    <= s2_row_q;
      s3_col_q    <= s2_col_q;
      s3_emit_q   <= s2_emit_q;
      s3_border_q <= s2_border_q;
      s3_ctr_q    <= win_q[4];
      s3_right_q  <= win_q[5];
      s3_below_q  <= win_q[7];
      s3_corner_q <= win_q[8];
      for (int j = 0; j < 3; j++) begin
        s3_min_q[j] <= srt_min[j];
        s3_mid_q[j] <= srt_mid[j];
        s3_max_q[j] <= srt_max[j];
      end
    end
  end

  // Median of nine: median of (max of lows, median of middles, min of highs)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      med_pix[k] = med3(max3(s3_min_q[0][k], s3_min_q[1][k], s3_min_q[2][k]),
                        med3(s3_mid_q[0][k], s3_mid_q[1][k], s3_mid_q[2][k]),
                        min3(s3_max_q[0][k], s3_max_q[1][k], s3_max_q[2][k]));
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: while the output does not stall, load a request's results and drain them one per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (adv) begin
      pend_q <= s3_valid_q ? s3_emit_q : '0;
    end else if (!out_stall_i) begin
      pend_q <= pend_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      b_row_q    <= s3_row_q;
      b_col_q    <= s3_col_q;
      b_border_q <= s3_border_q;
      b_pix0_q   <= s3_border_q ? s3_ctr_q : med_pix;
      b_pix1_q   <= s3_right_q;
      b_pix2_q   <= s3_below_q;
      b_pix3_q   <= s3_corner_q;
    end
  end

  // Present the lowest pending result
  always_comb begin
    out_row_o   = b_row_q;
    out_col_o   = 11'(b_col_q);
    out_pix     = b_pix3_q;
    is_border_o = 1'b1;
    if (pend_q[0]) begin
      out_row_o   = b_row_q - ROW_W'(1);
      out_col_o   = 11'(b_col_q - COL_W'(1));
      out_pix     = b_pix0_q;
      is_border_o = b_border_q;
    end else if (pend_q[1]) begin
      out_row_o = b_row_q - ROW_W'(1);
      out_pix   = b_pix1_q;
    end else if (pend_q[2]) begin
      out_col_o = 11'(b_col_q - COL_W'(1));
      out_pix   = b_pix2_q;
    end
  end

  assign out_valid_o   = pend_q != '0;
  assign last_of_run_o = pend_rest == '0;
  assign red_out_o     = out_pix[2];
  assign green_out_o   = out_pix[1];
  assign blue_out_o    = out_pix[0];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Line store write-back never collides with the read of a new request
  a_no_mem_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && accept) |-> (s1_col_q != c_cur))
    else $error("line store write and read at the same column");

  // Draining without advancing removes exactly one pending result
  a_drain_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && !out_stall_i) |=> ($countones(pend_q) == $countones($past(pend_q)) - 1))
    else $error("result register drained more or less than one result");

  // An interior pixel always produces the centered result
  a_interior_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_border_q) |-> s1_emit_q[0])
    else $error("interior pixel without its filtered result");

  // Column counter stays inside the row after a request
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_valid_i) |=> (WID_W'(col_q) < width_q))
    else $error("column counter past the row width");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the 3x3 RGB median filter core with a built-in window predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mf3rgb_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int CYCLE_LIMIT   = 100_000;
  localparam int DRAIN_SLACK   = 12;
  localparam int RANDOM_PIXELS = 80;

  // Indexes past the two defined registers; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [10:0]      col;
    pix_t             px;
    logic             border;
    logic             last;
  } result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           red_in_i      = '0;
  logic [7:0]           green_in_i    = '0;
  logic [7:0]           blue_in_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [ROW_W-1:0]     out_row_o;
  logic [10:0]          out_col_o;
  logic [7:0]           red_out_o;
  logic [7:0]           green_out_o;
  logic [7:0]           blue_out_o;
  logic                 is_border_o;
  logic                 last_of_run_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  // Predictor state: line stores, window, position counters, frame registers
  pix_t        older_line [MAX_WIDTH];
  pix_t        newer_line [MAX_WIDTH];
  pix_t        win [9] = '{default: '0};
  int          row_cnt = 0;
  int          col_cnt = 0;
  logic [11:0] width_reg  = 12'd640;
  logic [11:0] height_reg = 12'd480;

  result_t filtered_q [$];
  int      error_cnt       = 0;
  int      pixels_sent     = 0;
  int      results_checked = 0;
  int      cycle_cnt       = 0;
  int      stall_left      = 0;
  bit      quiet           = 1'b0;

  median_filter_3x3_rgb_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .is_border_o   (is_border_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Count cycles and abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Stall the result side in random bursts
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      stall_left  = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  = $urandom_range(1, 5) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    return (height_reg < MIN_DIM) ? MIN_DIM : int'(height_reg);
  endfunction

  function automatic result_t make_result(int row, int col, pix_t px, logic border);
    result_t res;
    res.row    = ROW_W'(row);
    res.col    = 11'(col);
    res.px     = px;
    res.border = border;
    res.last   = 1'b0;
    return res;
  endfunction

  // Bias channels toward the ends of the range and the sign boundary
  function automatic pix_t rand_pixel();
    pix_t p;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 7))
        0:       p[ch] = 8'h00;
        1:       p[ch] = 8'hFF;
        2:       p[ch] = 8'(127 + $urandom_range(0, 1));
        default: p[ch] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  // Advance the window by one pixel and queue the results it releases
  task automatic median_window_step(input pix_t px);
    int          w;
    int          h;
    int          r;
    int          c;
    int          n;
    int          j;
    pix_t        up2;
    pix_t        up1;
    pix_t        val;
    logic        interior;
    logic [7:0]  v [9];
    logic [7:0]  t;
    result_t     res [4];
    w = eff_width();
    h = eff_height();
    n = 0;
    // wrap counters left out of range by a size change
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    up2 = older_line[c];
    up1 = newer_line[c];
    older_line[c] = up1;
    newer_line[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3+1];
      win[i*3+1]   = win[i*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;
    // center pixel: per-channel median of nine, unsigned, or pass through on the edge
    if (r >= 1 && c >= 1) begin
      interior = (r - 1 >= 1) && (r - 1 <= h - 2) && (c - 1 >= 1) && (c - 1 <= w - 2);
      val = win[4];
      if (interior) begin
        for (int ch = 0; ch < 3; ch++) begin
          for (int i = 0; i < 9; i++) v[i] = win[i][ch];
          for (int i = 1; i < 9; i++) begin
            t = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > t) begin
              v[j+1] = v[j];
              j--;
            end
            v[j+1] = t;
          end
          val[ch] = v[4];
        end
      end
      res[n] = make_result(r - 1, c - 1, val, !interior);
      n++;
    end
    // flush the last column and the last row
    if (r >= 1 && c == w - 1) begin
      res[n] = make_result(r - 1, c, win[5], 1'b1);
      n++;
    end
    if (r == h - 1 && c >= 1) begin
      res[n] = make_result(r, c - 1, win[7], 1'b1);
      n++;
    end
    if (r == h - 1 && c == w - 1) begin
      res[n] = make_result(r, c, win[8], 1'b1);
      n++;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) filtered_q.insert(filtered_q.size(), res[i]);
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_cnt++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got row %0d col %0d", $time,
                 out_row_o, out_col_o);
        error_cnt++;
      end else begin
        want = filtered_q.pop_front();
        check_field("out_row", want.row, out_row_o);
        check_field("out_col", want.col, out_col_o);
        check_field("red_out", want.px[2], red_out_o);
        check_field("green_out", want.px[1], green_out_o);
        check_field("blue_out", want.px[0], blue_out_o);
        check_field("is_border", want.border, is_border_o);
        check_field("last_of_run", want.last, last_of_run_o);
        results_checked++;
      end
    end
  end

  // Send one pixel request, with an optional gap before it
  task automatic send_pixel(input pix_t px);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= px[2];
    green_in_i <= px[1];
    blue_in_i  <= px[0];
    do @(posedge clk_i); while (in_stall_o);
    median_window_step(px);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg  = data;
      CFG_IMAGE_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
  endtask

  // Start a row at the reset size, where no result is due, then shrink to 3x3 mid-row
  // and finish that frame
  task automatic test_reset_size();
    send_random(8);
    wait_drained();
    set_size(3, 3);
    send_random(6);
    wait_drained();
  endtask

  // Hand-picked 3x3 frame that separates unsigned from signed order and 5th from 6th, then a random 4x4 frame
  task automatic test_directed_frames();
    logic [7:0] red_seq   [9] = '{8'd130, 8'd0, 8'd250, 8'd60, 8'd190, 8'd30, 8'd220,
                                  8'd90, 8'd160};
    logic [7:0] blue_seq  [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255,
                                  8'd0, 8'd0};
    set_size(3, 3);
    // spare indexes must leave the frame size alone
    write_reg(CFG_SPARE_2, 12'hFFF);
    write_reg(CFG_SPARE_3, 12'h000);
    for (int i = 0; i < 9; i++) send_pixel({red_seq[i], 8'd255 - red_seq[i], blue_seq[i]});
    wait_drained();
    set_size(4, 4);
    send_random(16);
    wait_drained();
  endtask

  // Saturate out-of-range sizes, start a row at the widest size, then run a tall
  // frame for several rows
  task automatic test_out_of_range();
    set_size(0, 0);
    send_random(9);
    wait_drained();
    set_size(4095, 2);
    send_random(10);
    wait_drained();
    set_size(3, 4095);
    send_random(18);
    wait_drained();
  endtask

  // Shrink the width mid-row and the height at a row start
  task automatic test_mid_frame_change();
    set_size(8, 6);
    send_random(21);
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(4));
    send_random(12);
    wait_drained();
    set_size(3, 7);
    send_random(12);
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(3));
    send_random(9);
    wait_drained();
  endtask

  // Whole frames of random size and content
  task automatic test_random_frames();
    int w;
    int h;
    int start;
    start = pixels_sent;
    while (pixels_sent < start + RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2);
      else if ($urandom_range(0, 4) == 0) w = $urandom_range(11, 14);
      else w = $urandom_range(3, 10);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      set_size(w, h);
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_W'($urandom));
      end
      send_random(eff_width() * eff_height());
      wait_drained();
    end
  endtask

  // Back-to-back frame with both sides always ready
  task automatic test_full_rate();
    quiet = 1'b1;
    set_size(7, 4);
    send_random(28);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_size();
    test_directed_frames();
    test_out_of_range();
    test_mid_frame_change();
    test_random_frames();
    test_full_rate();
    $display("Sent %0d pixels and checked %0d results over small and random frames,",
             pixels_sent, results_checked);
    $display("saturated sizes, mid-frame size changes, spare writes and random stalls.");
    if (error_cnt == 0 && filtered_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
